// ----- design/sida_pkg.sv -----
// shared types, constants and helpers for the signed decimal ascii unit
`timescale 1ns / 1ps

package sida_pkg;

    // default width of the printed integer
    localparam int SIDA_WIDTH = 32;

    // magnitude bits absorbed by the digit cell row per clock
    localparam int SIDA_BITS_PER_STEP = 3;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // digit cell row control
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctl;

    // converter to character serializer handoff
    typedef struct packed {
        logic load;
        logic neg;
    } t_ser_ctl;

    // number of decimal digits of 2^(w-1), the largest magnitude
    function automatic int sida_num_digits(input int w);
        longint p;
        longint half;
        int     n;
        p    = 1;
        half = longint'(1) << (w - 1);
        n    = 1;
        while (p * 10 <= half) begin
            p = p * 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ----- design/sida_digit_cell.sv -----
// one bcd digit cell of the shift-add-3 row, several shift steps per clock
`timescale 1ns / 1ps

module sida_digit_cell
    import sida_pkg::*;
(
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic [3:0]                    i_load_digit,
    input  logic [SIDA_BITS_PER_STEP-1:0] i_carry,
    output logic [SIDA_BITS_PER_STEP-1:0] o_carry,
    output logic [3:0]                    o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    // step j: add 3 when 5 or more, then shift in the bit from below
    always_comb begin
        logic [3:0] v;
        logic [3:0] adj;
        v       = r_digit;
        adj     = r_digit;
        o_carry = '0;
        for (int j = 0; j < SIDA_BITS_PER_STEP; j++) begin
            adj        = (v >= 4'd5) ? (v + 4'd3) : v;
            o_carry[j] = adj[3];
            v          = {adj[2:0], i_carry[j]};
        end
        n_digit = v;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctl.step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// ----- design/sida_char_out.sv -----
// character serializer: sign, then digits with leading zeros dropped
`timescale 1ns / 1ps

module sida_char_out
    import sida_pkg::*;
#(
    parameter int NUM_DIGITS = sida_num_digits(SIDA_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ser_ctl                i_ctl,
    input  logic [NUM_DIGITS*4-1:0] i_digits,
    output logic                    o_ready,
    output logic                    o_strobe,
    output logic [7:0]              o_char_code,
    output logic                    o_last
);

    localparam int CW = $clog2(NUM_DIGITS + 1);

    logic                    r_neg_pend;
    logic                    n_neg_pend;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           n_cnt;
    logic [NUM_DIGITS*4-1:0] r_digits;
    logic [NUM_DIGITS*4-1:0] n_digits;
    logic                    r_lead;
    logic                    n_lead;
    logic                    r_strobe;
    logic                    n_strobe;
    logic [7:0]              r_char;
    logic [7:0]              n_char;
    logic                    r_last;
    logic                    n_last;
    logic [3:0]              w_top;

    assign w_top = r_digits[NUM_DIGITS*4-1 -: 4];

    // free when idle or on the final digit position of the current number
    assign o_ready = !r_neg_pend && (r_cnt <= CW'(1));

    always_comb begin
        n_neg_pend = r_neg_pend;
        n_cnt      = r_cnt;
        n_digits   = r_digits;
        n_lead     = r_lead;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = 1'b0;
        if (r_neg_pend) begin
            n_strobe   = 1'b1;
            n_char     = CH_MINUS;
            n_neg_pend = 1'b0;
        end else if (r_cnt != '0) begin
            if ((w_top != 4'd0) || r_lead || (r_cnt == CW'(1))) begin
                n_strobe = 1'b1;
                n_char   = CH_ZERO + {4'd0, w_top};
                n_last   = (r_cnt == CW'(1));
                n_lead   = 1'b1;
            end
            n_digits = r_digits << 4;
            n_cnt    = r_cnt - CW'(1);
        end
        if (i_ctl.load) begin
            n_neg_pend = i_ctl.neg;
            n_digits   = i_digits;
            n_cnt      = CW'(NUM_DIGITS);
            n_lead     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_pend <= 1'b0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_neg_pend <= n_neg_pend;
            r_cnt      <= n_cnt;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_lead   <= n_lead;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ----- design/signed_int_to_decimal_ascii_unit.sv -----
// top level: signed integer to decimal ascii text, one character per strobe
// flow: the digit cell row converts the next number (3 bits a clock) while the serializer
//   prints the previous one; characters are strobed one at a time, with gaps where leading
//   zeros are dropped, and the row hands its digits over only when the serializer is ready
//   to take them; the next number can be taken in that same cycle
// reset: i_rst_n is synchronous, active low, and clears all control state
// the receiver cannot stall: every strobed character is taken in its cycle
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit
    import sida_pkg::*;
#(
    parameter int WIDTH = SIDA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_char_code,
    output logic        o_last
);

    // number of decimal digit cells in the row
    localparam int ND    = sida_num_digits(WIDTH);
    localparam int K     = SIDA_BITS_PER_STEP;
    // shift steps per conversion, magnitude padded up to a multiple of K
    localparam int STEPS = (WIDTH + K - 1) / K;
    localparam int MW    = STEPS * K;
    // bits left in the shifter after the first K go straight into the units cell
    localparam int SHW   = MW - K;
    localparam int SCW   = $clog2(STEPS);

    logic                 r_active;
    logic                 n_active;
    logic [SCW-1:0]       r_cnt;
    logic [SCW-1:0]       n_cnt;
    logic                 r_neg;
    logic                 n_neg;
    logic [SHW-1:0]       r_shreg;
    logic [SHW-1:0]       n_shreg;

    logic                 w_accept;
    logic                 w_handoff;
    logic                 w_ser_ready;
    logic [WIDTH-1:0]     w_x;
    logic                 w_x_neg;
    logic [WIDTH-1:0]     w_mag;
    logic [MW-1:0]        w_padded;
    logic [3:0]           w_first_digit;
    t_cell_ctl            w_cell_ctl;
    t_ser_ctl             w_ser_ctl;
    logic [K-1:0]         w_carry [ND+1];
    logic [ND*4-1:0]      w_digits;

    // ---------------------------------------------------------------
    // input: take the low WIDTH bits and form the magnitude; the most
    // negative value maps onto 2^(WIDTH-1), which still fits in WIDTH bits
    // ---------------------------------------------------------------
    assign w_x      = i_value[WIDTH-1:0];
    assign w_x_neg  = w_x[WIDTH-1];
    assign w_mag    = w_x_neg ? (~w_x + WIDTH'(1)) : w_x;
    assign w_padded = MW'(w_mag);

    // the first K shift steps on cleared digits just drop the top K bits
    // into the units cell, so they are folded into the load
    assign w_first_digit = 4'(w_padded[MW-1 -: K]);

    // ---------------------------------------------------------------
    // handshake: the converter finishes and hands its digits to the
    // serializer, and in that same cycle a next transaction can be taken
    // ---------------------------------------------------------------
    assign w_handoff = r_active && (r_cnt == '0) && w_ser_ready;
    assign busy      = r_active && !w_handoff;
    assign w_accept  = start && !busy;

    assign w_cell_ctl.load = w_accept;
    assign w_cell_ctl.step = r_active && (r_cnt != '0);

    assign w_ser_ctl.load = w_handoff;
    assign w_ser_ctl.neg  = r_neg;

    always_comb begin
        n_active = r_active;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_shreg  = r_shreg;
        if (w_accept) begin
            n_active = 1'b1;
            n_cnt    = SCW'(STEPS - 1);
            n_neg    = w_x_neg;
            n_shreg  = w_padded[SHW-1:0];
        end else if (w_handoff) begin
            n_active = 1'b0;
        end else if (w_cell_ctl.step) begin
            n_cnt   = r_cnt - SCW'(1);
            n_shreg = r_shreg << K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_shreg <= n_shreg;
    end

    // ---------------------------------------------------------------
    // digit cell row: magnitude bits enter the units cell msb first,
    // each cell passes its shifted-out bits to the next higher digit
    // ---------------------------------------------------------------
    for (genvar j = 0; j < K; j++) begin : g_feed
        assign w_carry[0][j] = r_shreg[SHW-1-j];
    end

    for (genvar g = 0; g < ND; g++) begin : g_cell
        sida_digit_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_cell_ctl),
            .i_load_digit ((g == 0) ? w_first_digit : 4'd0),
            .i_carry      (w_carry[g]),
            .o_carry      (w_carry[g+1]),
            .o_digit      (w_digits[4*g +: 4])
        );
    end

    // ---------------------------------------------------------------
    // character serializer with registered outputs
    // ---------------------------------------------------------------
    sida_char_out #(
        .NUM_DIGITS (ND)
    ) u_char_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ser_ctl),
        .i_digits    (w_digits),
        .o_ready     (w_ser_ready),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a new transaction keeps the converter occupied for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low right after a transaction was taken");

    // digits go to the serializer only once every shift step is done
    a_handoff_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_handoff |-> (r_cnt == '0) && !w_accept || (r_cnt == '0))
        else $error("handoff before the cell row finished");

    // the magnitude always fits the row, nothing spills out of the top digit
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_ctl.step |-> (w_carry[ND] == '0))
        else $error("carry out of the most significant digit cell");

    // only a sign or a decimal digit is ever emitted
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_char_code == CH_MINUS) ||
                     ((o_char_code >= CH_ZERO) && (o_char_code <= CH_ZERO + 8'd9)))
        else $error("emitted character is neither sign nor digit");

    // the sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_char_code == CH_MINUS)) |-> !o_last)
        else $error("sign flagged as the last character");

endmodule

// ----- tb/sida_text_checker.sv -----
// checker for the signed decimal ascii unit: predicts each number's text and compares characters
`timescale 1ns / 1ps

module sida_text_checker
    import sida_pkg::*;
#(
    parameter int WIDTH = SIDA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_value,
    input  logic        i_strobe,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_text_char;

    t_text_char expected_text[$];

    // decimal text of one number, appended to the expected characters
    function automatic void queue_decimal_text(input logic [31:0] value);
        int         w;
        logic [63:0] full;
        logic [63:0] x;
        logic [63:0] mag;
        logic       neg;
        logic [3:0] digits[$];
        w    = (WIDTH < 16) ? 16 : ((WIDTH > 32) ? 32 : WIDTH);
        full = 64'd1 << w;
        x    = {32'd0, value} & (full - 64'd1);
        neg  = x[w-1];
        mag  = neg ? (full - x) : x;
        do begin
            digits.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg) begin
            expected_text.push_back('{char_code: CH_MINUS, last: 1'b0});
        end
        foreach (digits[i]) begin
            expected_text.push_back('{char_code: CH_ZERO + 8'(digits[i]),
                                      last: (i == digits.size() - 1)});
        end
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_text_char want;
        logic       bad;
        bad = 1'b0;
        if (i_rst_n) begin
            // characters are checked before the new number is queued
            if (i_strobe) begin
                if (expected_text.size() == 0) begin
                    $error("char_code: unexpected character %0d, none expected", i_char_code);
                    bad = 1'b1;
                end else begin
                    want = expected_text.pop_front();
                    if (i_char_code !== want.char_code) begin
                        $error("char_code: expected %0d, actual %0d",
                               want.char_code, i_char_code);
                        bad = 1'b1;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        bad = 1'b1;
                    end
                end
            end
            if (bad) begin
                o_mismatches <= o_mismatches + 1;
            end
            if (i_start && !i_busy) begin
                queue_decimal_text(i_value);
            end
        end
        o_pending <= expected_text.size();
    end

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii_unit.sv -----
// testbench top for the signed decimal ascii unit: stimulus, timeout and verdict
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;
    import sida_pkg::*;

    localparam int WIDTH        = SIDA_WIDTH;
    // per-phase chance, in percent, that the sender idles once more before offering a number
    localparam int IDLE_NONE    = 0;
    localparam int IDLE_HEAVY   = 83;
    localparam int IDLE_LIGHT   = 11;
    localparam int PHASE_ITEMS  = 90;
    // worst case is far below this: 384 numbers of at most 11 characters each,
    // plus the conversion time and an idle gap per number
    localparam int LIMIT_CYCLES = 400000;
    // drain time after the last character, before the verdict
    localparam int TAIL_CYCLES  = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic        o_strobe;
    logic [7:0]  o_char_code;
    logic        o_last;
    int          mismatches;
    int          pending;
    int          cycle_count = 0;

    // extremes, digit-count boundaries and the most negative value
    int directed_values[24] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, 10000, -10000, 1000000,
        123456789, -123456789, 999999999, 1000000000, -1000000000, 1000000001,
        2147483646, 2147483647, -2147483647, 32'h8000_0000,
        32'h5555_5555, 32'haaaa_aaaa
    };

    int idle_by_phase[4] = '{IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT, IDLE_NONE};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_int_to_decimal_ascii_unit #(
        .WIDTH(WIDTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_strobe   (o_strobe),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

    sida_text_checker #(
        .WIDTH(WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_value     (i_value),
        .i_strobe    (o_strobe),
        .i_char_code (o_char_code),
        .i_last      (o_last),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // one transaction: optional idle cycles with noise on the value, then hold
    // start until an edge sees busy low; start stays high on return so the next
    // number can follow back to back
    task automatic send_number(input logic [31:0] value, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // sender holds off until every queued character has come out
    task automatic drain_text();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // mostly short magnitudes of either sign, some full-range words and some
    // values at or next to a power of ten
    function automatic logic [31:0] random_number();
        int p;
        int v;
        p = 1;
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) != 0) v = -v;
            end
        endcase
        return v;
    endfunction

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_signed_int_to_decimal_ascii_unit failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed numbers back to back, then a full drain before random traffic
        foreach (directed_values[i]) begin
            send_number(directed_values[i], IDLE_NONE);
        end
        drain_text();

        // random phases: no idling, heavy idling, light idling, no idling again
        foreach (idle_by_phase[ph]) begin
            repeat (PHASE_ITEMS) begin
                send_number(random_number(), idle_by_phase[ph]);
            end
            drain_text();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_signed_int_to_decimal_ascii_unit passed");
        end else begin
            $display("tb_signed_int_to_decimal_ascii_unit failed");
        end
        $finish;
    end

endmodule
